// ===== rtl/byte_string_midpoint_defines.svh =====
// ----------------------------------------------------------------------------
// Byte-string midpoint assertion macros
// Concurrent assertion shorthands, clocked on clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_STRING_MIDPOINT_DEFINES_SVH
`define BYTE_STRING_MIDPOINT_DEFINES_SVH

// same-cycle implication
`define BSM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte-string midpoint package
// Shared constants, payload structs, sequencer states and step unit types.
// ----------------------------------------------------------------------------
package bsm_pkg;

   localparam int BYTE_W          = 8;
   localparam int KEY_LEN_DEFAULT = 64;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_a;
      logic              has_a;
      logic [BYTE_W-1:0] byte_b;
      logic              has_b;
      logic              plus_one;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] mid_byte;
      logic              last_byte;
      logic              empty_res;
      logic              truncated;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_RD,
      ST_EX,
      ST_FIN,
      ST_ERD,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic              cin;
      logic [BYTE_W-1:0] prev;
      logic              inc;
      logic              fin;
   } step_in_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sum;
      logic              cout;
      logic [BYTE_W-1:0] mid;
      logic              inc_out;
   } step_out_type;

endpackage

// ===== rtl/byte_string_midpoint.sv =====
// ----------------------------------------------------------------------------
// Byte-string midpoint
// Loads two keys one position per request, then runs a shared byte step unit
// down the stored keys and emits the midpoint most significant byte first.
// ----------------------------------------------------------------------------
// Sequencing: requests are taken only in ST_LOAD. After the last request the single
//   step unit walks the keys through ST_RD and ST_EX, one registered key RAM read per
//   position, then ST_FIN; each result then takes a registered midpoint RAM read in
//   ST_ERD and is loaded in ST_EMIT once the output register is ready.
// Reset: synchronous; clears the sequencer, counters and overflow flag. The
//   key and midpoint RAMs are not cleared; only written positions are read.
module byte_string_midpoint
   import bsm_pkg::*;
#(
   parameter int MAX_KEY_LEN = KEY_LEN_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
   localparam int CW = $clog2(MAX_KEY_LEN + 1);
   localparam logic [CW-1:0] LEN_MAX = CW'(MAX_KEY_LEN);

   logic [2*BYTE_W-1:0] key_mem_ff [MAX_KEY_LEN];
   logic [BYTE_W-1:0]   mid_mem_ff [MAX_KEY_LEN];

   state_type           state_ff, state_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       len_a_ff, len_a_in;
   logic [CW-1:0]       len_b_ff, len_b_in;
   logic                ovf_ff, ovf_in;
   logic                inc_ff, inc_in;
   logic [AW-1:0]       k_ff, k_in;
   logic [AW-1:0]       last_idx_ff, last_idx_in;
   logic                first_ff, first_in;
   logic                carry_ff, carry_in;
   logic [BYTE_W-1:0]   prev_ff, prev_in;
   logic                inc_c_ff, inc_c_in;
   logic [2*BYTE_W-1:0] key_rd_ff;
   logic [BYTE_W-1:0]   mid_rd_ff;

   logic                key_we;
   logic [2*BYTE_W-1:0] key_wdata;
   logic                key_re;
   logic                mid_we;
   logic [AW-1:0]       mid_waddr;
   logic [BYTE_W-1:0]   mid_wdata;
   logic                mid_re;
   logic [CW-1:0]       n_len;
   logic [CW-1:0]       n_m1;
   step_in_type         step_i;
   step_out_type        step_o;
   logic                out_load;
   logic                out_ready;
   rsp_type             out_data;

   bsm_step u_step (
      .step_i (step_i),
      .step_o (step_o)
   );

   bsm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = (state_ff != ST_LOAD);

   always_comb begin
      n_len = (len_a_ff > len_b_ff) ? len_a_ff : len_b_ff;
      n_m1  = n_len - CW'(1);
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      len_a_in    = len_a_ff;
      len_b_in    = len_b_ff;
      ovf_in      = ovf_ff;
      inc_in      = inc_ff;
      k_in        = k_ff;
      last_idx_in = last_idx_ff;
      first_in    = first_ff;
      carry_in    = carry_ff;
      prev_in     = prev_ff;
      inc_c_in    = inc_c_ff;
      key_we      = 1'b0;
      key_wdata   = {(req_data.has_a ? req_data.byte_a : {BYTE_W{1'b0}}),
                     (req_data.has_b ? req_data.byte_b : {BYTE_W{1'b0}})};
      key_re      = 1'b0;
      mid_we      = 1'b0;
      mid_waddr   = k_ff + AW'(1);
      mid_wdata   = step_o.mid;
      mid_re      = 1'b0;
      out_load    = 1'b0;
      out_data    = '0;
      step_i.a    = key_rd_ff[2*BYTE_W-1:BYTE_W];
      step_i.b    = key_rd_ff[BYTE_W-1:0];
      step_i.cin  = carry_ff;
      step_i.prev = prev_ff;
      step_i.inc  = inc_c_ff;
      step_i.fin  = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (pos_ff < LEN_MAX) begin
                  key_we = 1'b1;
                  pos_in = pos_ff + CW'(1);
                  if (req_data.has_a) begin
                     len_a_in = pos_ff + CW'(1);
                  end
                  if (req_data.has_b) begin
                     len_b_in = pos_ff + CW'(1);
                  end
               end else if (req_data.has_a || req_data.has_b) begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  inc_in   = req_data.plus_one;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (n_len == '0) begin
               state_in = ST_EMPTY;
            end else begin
               k_in        = n_m1[AW-1:0];
               last_idx_in = n_m1[AW-1:0];
               first_in    = 1'b1;
               carry_in    = 1'b0;
               inc_c_in    = inc_ff;
               state_in    = ST_RD;
            end
         end
         ST_RD: begin
            key_re   = 1'b1;
            state_in = ST_EX;
         end
         ST_EX: begin
            prev_in  = step_o.sum;
            carry_in = step_o.cout;
            first_in = 1'b0;
            if (!first_ff) begin
               mid_we   = 1'b1;
               inc_c_in = step_o.inc_out;
            end
            if (k_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               k_in     = k_ff - AW'(1);
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            step_i.a    = '0;
            step_i.b    = '0;
            step_i.fin  = 1'b1;
            mid_we      = 1'b1;
            mid_waddr   = '0;
            k_in        = '0;
            state_in    = ST_ERD;
         end
         ST_ERD: begin
            mid_re   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_ready) begin
               out_load           = 1'b1;
               out_data.mid_byte  = mid_rd_ff;
               out_data.last_byte = (k_ff == last_idx_ff);
               out_data.empty_res = 1'b0;
               out_data.truncated = ovf_ff;
               if (k_ff == last_idx_ff) begin
                  pos_in   = '0;
                  len_a_in = '0;
                  len_b_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = ST_ERD;
               end
            end
         end
         ST_EMPTY: begin
            if (out_ready) begin
               out_load           = 1'b1;
               out_data.mid_byte  = '0;
               out_data.last_byte = 1'b1;
               out_data.empty_res = 1'b1;
               out_data.truncated = ovf_ff;
               pos_in             = '0;
               len_a_in           = '0;
               len_b_in           = '0;
               ovf_in             = 1'b0;
               state_in           = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         pos_ff   <= '0;
         len_a_ff <= '0;
         len_b_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_ff      <= inc_in;
      k_ff        <= k_in;
      last_idx_ff <= last_idx_in;
      first_ff    <= first_in;
      carry_ff    <= carry_in;
      prev_ff     <= prev_in;
      inc_c_ff    <= inc_c_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem_ff[pos_ff[AW-1:0]] <= key_wdata;
      end
      if (key_re) begin
         key_rd_ff <= key_mem_ff[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mid_we) begin
         mid_mem_ff[mid_waddr] <= mid_wdata;
      end
      if (mid_re) begin
         mid_rd_ff <= mid_mem_ff[k_ff];
      end
   end

endmodule

// ===== rtl/bsm_step.sv =====
// ----------------------------------------------------------------------------
// Byte-string midpoint step unit
// One byte of add, halve and increment, shared across every position.
// ----------------------------------------------------------------------------
module bsm_step
   import bsm_pkg::*;
(
   input  step_in_type  step_i,
   output step_out_type step_o
);

   logic [BYTE_W:0]   sum_w;
   logic [BYTE_W:0]   mid_w;
   logic              top_bit;
   logic [BYTE_W-1:0] half;

   always_comb begin
      sum_w   = {1'b0, step_i.a} + {1'b0, step_i.b} + {{BYTE_W{1'b0}}, step_i.cin};
      top_bit = step_i.fin ? step_i.cin : sum_w[0];
      half    = {top_bit, step_i.prev[BYTE_W-1:1]};
      mid_w   = {1'b0, half} + {{BYTE_W{1'b0}}, step_i.inc};
      step_o.sum     = sum_w[BYTE_W-1:0];
      step_o.cout    = sum_w[BYTE_W];
      step_o.mid     = mid_w[BYTE_W-1:0];
      step_o.inc_out = mid_w[BYTE_W];
   end

endmodule

// ===== rtl/bsm_out.sv =====
// ----------------------------------------------------------------------------
// Byte-string midpoint output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module bsm_out
   import bsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   always_comb begin
      ready    = !valid_ff || !rsp_stall;
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/bsm_check.sv =====
// ----------------------------------------------------------------------------
// Byte-string midpoint port checker
// Watches the request and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "byte_string_midpoint_defines.svh"

module bsm_check
   import bsm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `BSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `BSM_ASSERT_NOW(a_empty_last, rsp_valid && rsp_data.empty_res, rsp_data.last_byte && (rsp_data.mid_byte == '0), "empty result malformed")
   `BSM_ASSERT_NEXT(a_load_open, req_valid && !req_stall && !req_data.last, !req_stall, "stalled inside a key pair")
   `BSM_ASSERT_NEXT(a_last_busy, req_valid && !req_stall && req_data.last, req_stall, "took request after last")
   `BSM_ASSERT_NOW(a_emit_busy, rsp_valid && !rsp_data.last_byte, req_stall, "request taken mid-emission")

endmodule

bind byte_string_midpoint bsm_check u_bsm_check (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Byte-string midpoint testbench
// Streams key pairs into the block one position per request and checks every
// midpoint byte against a local predictor or a typed row's expected result.
// It opens with a directed table and a run past the key-length bound, then sends
// random key pairs in phases with idle and stall pressure and one long output hold.
// ----------------------------------------------------------------------------
module tb
   import bsm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_LEN     = KEY_LEN_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 2 * KEY_LEN + 8;
   localparam int PHASE_ITEMS = 56;
   localparam int HOLD_AT     = 120;
   localparam int HOLD_CYCLES = 400;
   localparam int DIR_ROWS    = 16;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   localparam int IDLE_PCT  [4] = '{0, 59, 0, 13};
   localparam int STALL_PCT [4] = '{0, 0, 59, 13};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [BYTE_W-1:0] key_a_mem [KEY_LEN];
   logic [BYTE_W-1:0] key_b_mem [KEY_LEN];
   logic [6:0]        len_a   = '0;
   logic [6:0]        len_b   = '0;
   logic [6:0]        pos_cnt = '0;
   logic              ovf     = 1'b0;

   rsp_type mid_bytes_out [$];
   rsp_type pending_mid   [$];

   int idle_pct   = 0;
   int stall_pct  = 0;
   int items_sent = 0;
   int fail_count = 0;
   int cycle_count;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{'{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{'{8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
      '{'{8'h00, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b0}},
      '{'{8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{8'h80, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1}, 1'b1, '{8'h40, 1'b1, 1'b0, 1'b0}},
      '{'{8'h00, 1'b0, 8'h7F, 1'b1, 1'b1, 1'b1}, 1'b1, '{8'h40, 1'b1, 1'b0, 1'b0}},
      '{'{8'hFF, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
      '{'{8'h12, 1'b1, 8'h34, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'hAB, 1'b0, 8'hCD, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'h01, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b1, 8'h01, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{'{8'h55, 1'b1, 8'hAA, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h3C, 1'b1, 8'hC3, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hF0, 1'b0, 8'h0F, 1'b0, 1'b1, 1'b1}, 1'b0, '0}
   };

   byte_string_midpoint #(
      .MAX_KEY_LEN(KEY_LEN)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic fold_position(input req_type r);
      int                n;
      int                carry;
      int                rem;
      int                v;
      logic [BYTE_W-1:0] sum_b [KEY_LEN];
      logic [BYTE_W-1:0] mid_b [KEY_LEN];
      rsp_type           res;
      mid_bytes_out.delete();
      if (pos_cnt < KEY_LEN) begin
         key_a_mem[pos_cnt[5:0]] = r.has_a ? r.byte_a : 8'h00;
         key_b_mem[pos_cnt[5:0]] = r.has_b ? r.byte_b : 8'h00;
         if (r.has_a) len_a = pos_cnt + 7'd1;
         if (r.has_b) len_b = pos_cnt + 7'd1;
         pos_cnt = pos_cnt + 7'd1;
      end else if (r.has_a || r.has_b) begin
         ovf = 1'b1;
      end
      if (!r.last) return;
      n = (len_a > len_b) ? len_a : len_b;
      if (n == 0) begin
         res = '{8'h00, 1'b1, 1'b1, ovf};
         mid_bytes_out.push_back(res);
      end else begin
         carry = 0;
         for (int k = n - 1; k >= 0; k--) begin
            v        = key_a_mem[k] + key_b_mem[k] + carry;
            sum_b[k] = v[7:0];
            carry    = v >> 8;
         end
         rem = carry;
         for (int i = 0; i < n; i++) begin
            v        = (rem << 8) + sum_b[i];
            mid_b[i] = 8'(v >> 1);
            rem      = v & 1;
         end
         carry = r.plus_one;
         for (int k = n - 1; k >= 0; k--) begin
            v        = mid_b[k] + carry;
            mid_b[k] = v[7:0];
            carry    = v >> 8;
         end
         for (int i = 0; i < n; i++) begin
            res = '{mid_b[i], (i == n - 1), 1'b0, ovf};
            mid_bytes_out.push_back(res);
         end
      end
      len_a   = '0;
      len_b   = '0;
      pos_cnt = '0;
      ovf     = 1'b0;
   endtask

   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fold_position(r);
      if (typed && r.last) begin
         pending_mid.push_back(want);
      end else begin
         foreach (mid_bytes_out[i]) pending_mid.push_back(mid_bytes_out[i]);
      end
      items_sent++;
   endtask

   task automatic send_random_pair();
      int      sel;
      int      len;
      int      em;
      req_type r;
      sel = $urandom_range(99);
      if (sel < 70)      len = $urandom_range(8, 1);
      else if (sel < 90) len = $urandom_range(32, 9);
      else if (sel < 97) len = $urandom_range(KEY_LEN, 33);
      else               len = $urandom_range(KEY_LEN + 6, KEY_LEN + 1);
      em = $urandom_range(9);
      for (int p = 0; p < len; p++) begin
         r.byte_a   = 8'($urandom);
         r.byte_b   = 8'($urandom);
         r.has_a    = (em == 0 || em == 2) ? 1'b0 : ($urandom_range(99) < 85);
         r.has_b    = (em == 1 || em == 2) ? 1'b0 : ($urandom_range(99) < 85);
         r.plus_one = 1'($urandom);
         r.last     = (p == len - 1);
         send_request(r, 1'b0, '0);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_mid.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // output side: check accepted results, then pick next stall
   initial begin
      int      hold_left;
      bit      hold_done;
      rsp_type want;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_mid.size() == 0) begin
               $error("unexpected result: mid_byte %h last_byte %b", rsp_data.mid_byte,
                      rsp_data.last_byte);
               fail_count++;
            end else begin
               want = pending_mid.pop_front();
               if (rsp_data.mid_byte !== want.mid_byte) begin
                  $error("mid_byte: expected %h, got %h", want.mid_byte, rsp_data.mid_byte);
                  fail_count++;
               end
               if (rsp_data.last_byte !== want.last_byte) begin
                  $error("last_byte: expected %b, got %b", want.last_byte, rsp_data.last_byte);
                  fail_count++;
               end
               if (rsp_data.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %b, got %b", want.empty_res, rsp_data.empty_res);
                  fail_count++;
               end
               if (rsp_data.truncated !== want.truncated) begin
                  $error("truncated: expected %b, got %b", want.truncated, rsp_data.truncated);
                  fail_count++;
               end
            end
         end
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** byte_string_midpoint: FAILED **");
      $finish;
   end

   initial begin
      req_type r;
      int      target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end

      // full-length key pair, then one byte past the bound
      for (int p = 0; p <= KEY_LEN; p++) begin
         r.byte_a   = 8'($urandom);
         r.byte_b   = 8'($urandom);
         r.has_a    = (p < KEY_LEN);
         r.has_b    = 1'b1;
         r.plus_one = 1'b1;
         r.last     = (p == KEY_LEN);
         send_request(r, 1'b0, '0);
      end
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = IDLE_PCT[ph];
         stall_pct = STALL_PCT[ph];
         target    = items_sent + PHASE_ITEMS;
         while (items_sent < target) send_random_pair();
         drain_results();
      end

      if (fail_count == 0) begin
         $display("** byte_string_midpoint: PASSED **");
      end else begin
         $display("** byte_string_midpoint: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bsm_pkg.sv
rtl/bsm_step.sv
rtl/bsm_out.sv
rtl/byte_string_midpoint.sv
rtl/bsm_check.sv
bench/tb.sv
